// ===== design/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the Bloom filter membership block
// Holds the item structs, the sequencer states and the hash constants.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int unsigned DEF_MAX_BITS      = 65536;
  localparam int unsigned DEF_MAX_PROBES    = 16;
  localparam int unsigned DEF_MAX_KEY_BYTES = 64;

  // Widths of the configuration registers.
  localparam int unsigned FB_W = 17;
  localparam int unsigned HC_W = 5;
  // Width of the reduced probe modulus.
  localparam int unsigned MW   = 17;

  localparam logic [FB_W-1:0] FB_RESET = 17'd65536;
  localparam logic [HC_W-1:0] HC_RESET = 5'd4;

  localparam logic [31:0] C1     = 32'hcc9e2d51;
  localparam logic [31:0] C2     = 32'h1b873593;
  localparam logic [31:0] C3     = 32'h85ebca6b;
  localparam logic [31:0] C4     = 32'hc2b2ae35;
  localparam logic [31:0] H_MUL  = 32'd5;
  localparam logic [31:0] H_ADD  = 32'he6546b64;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef enum logic [0:0] {
    REG_FILTER_BITS = 1'b0,
    REG_HASH_COUNT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        func;
    logic [31:0] key_word;
    logic [2:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BYTE,
    ST_PINIT,
    ST_RD,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_H5,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_MOD,
    ST_BIT,
    ST_CHK,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] d;
    d = {x, x} << r;
    return d[63:32];
  endfunction

endpackage

// ===== design/bfm_mod.sv =====
// ----------------------------------------------------------------------------
// bfm_mod: iterative 32-bit remainder unit
// Restoring division, one dividend bit per cycle; keeps only the remainder.
// ----------------------------------------------------------------------------
module bfm_mod
  import bfm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [MW-1:0] divisor,
  output logic          done,
  output logic [MW-1:0] rem
);

  logic [31:0]   dvd_r, dvd_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [MW:0]   trial;

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, dvd_r[31]};
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[MW-1:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = (cnt_r == 6'd0) && !start;
  assign rem  = rem_r;

endmodule

// ===== design/bloom_filter_membership.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_membership: Bloom filter with MurmurHash3 probes
// Buffers a key, hashes it once per probe and sets or tests store bits.
// ----------------------------------------------------------------------------
// Usage. Keys arrive on the in_ channel as a run of items, each holding up
// to four little-endian key bytes, and the run ends at the item marked last.
// The func field of the last item selects add or lookup. Each last item
// produces exactly one result on the out_ channel: found and status. Other
// items produce nothing. The user writes filter_bits and hash_count through
// the APB port only while the block is idle; the block does not enforce it.
// Operation. An item is taken in ST_IDLE and its bytes are then buffered one
// per cycle in ST_BYTE; the next item is accepted only back in ST_IDLE.
// After the last item each probe hashes the buffered key word by word and
// then runs the final mix; a lookup probe also passes through ST_CHK.
// One shared 32x32 multiplier steps through the hash rounds, a bit-serial
// remainder unit reduces the hash to a store position, then the bit store is
// written or read. A lookup stops at the first clear bit, and the result is
// loaded in ST_EMIT. in_stall is high for the whole of this work.
// Reset. After rst_n the bit store is cleared one bit per cycle, with in_stall
// held high; configuration writes are taken meanwhile.
// Stall. A finished result waits in the output register while out_stall is
// high; the next key can be collected meanwhile, but its result is held
// back until the register has been taken.
// ----------------------------------------------------------------------------
module bloom_filter_membership
  import bfm_pkg::*;
#(
  parameter int unsigned MAX_BITS      = DEF_MAX_BITS,
  parameter int unsigned MAX_PROBES    = DEF_MAX_PROBES,
  parameter int unsigned MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_BITS);
  localparam int unsigned LW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned BW = LW - 2;
  localparam int unsigned KW = (MAX_KEY_BYTES + 3) / 4;
  localparam int unsigned KA = (KW > 1) ? $clog2(KW) : 1;
  localparam int unsigned PW = $clog2(MAX_PROBES + 1) + 1;

  // Configuration registers.
  logic [FB_W-1:0] fb_r;
  logic [HC_W-1:0] hc_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FB_RESET;
      hc_r <= HC_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_FILTER_BITS: fb_r <= pwdata[FB_W-1:0];
        REG_HASH_COUNT:  hc_r <= pwdata[HC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_FILTER_BITS: prdata = {{(32-FB_W){1'b0}}, fb_r};
      REG_HASH_COUNT:  prdata = {{(32-HC_W){1'b0}}, hc_r};
      default:         prdata = '0;
    endcase
  end

  // Effective modulus and probe count, saturated as the block defines them.
  logic [MW-1:0] modulus;
  logic [PW-1:0] probes;

  always_comb begin
    if (fb_r == '0) begin
      modulus = MW'(1);
    end else if (32'(fb_r) > 32'(MAX_BITS)) begin
      modulus = MW'(MAX_BITS);
    end else begin
      modulus = fb_r;
    end
    if (32'(hc_r) > 32'(MAX_PROBES)) begin
      probes = PW'(MAX_PROBES);
    end else begin
      probes = PW'(hc_r);
    end
  end

  // Sequencer registers.
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [31:0]     word_r, word_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [2:0]      bidx_r, bidx_nxt;
  logic            last_r, last_nxt;
  logic            func_r, func_nxt;
  logic [LW-1:0]   klen_r, klen_nxt;
  logic            ovf_r, ovf_nxt;
  logic [PW-1:0]   probe_r, probe_nxt;
  logic [BW-1:0]   blk_r, blk_nxt;
  logic [31:0]     h_r, h_nxt;
  logic [31:0]     p_r;
  logic            found_r, found_nxt;
  logic            status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;

  // Key buffer, byte-lane writes, registered word reads.
  logic [31:0]   kmem [KW];
  logic [31:0]   krd_r;
  logic          kwe;
  logic [7:0]    kbyte;

  // Bit store.
  logic          bmem [MAX_BITS];
  logic          brd_r;
  logic          bwe;
  logic [AW-1:0] bwaddr;
  logic          bwdata;

  // Remainder unit.
  logic          mod_start;
  logic          mod_done;
  logic [MW-1:0] mod_rem;
  logic [AW-1:0] pos;

  logic [BW-1:0] nblocks;
  logic [1:0]    tail;
  logic [31:0]   kmask;
  logic [31:0]   t;
  logic [2:0]    bc_sat;
  logic          last_probe;

  assign nblocks    = klen_r[LW-1:2];
  assign tail       = klen_r[1:0];
  assign pos        = AW'(mod_rem);
  assign last_probe = (probe_r + PW'(1)) == probes;
  assign bc_sat     = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;

  always_comb begin
    case (tail)
      2'd1:    kmask = 32'h0000_00ff;
      2'd2:    kmask = 32'h0000_ffff;
      2'd3:    kmask = 32'h00ff_ffff;
      default: kmask = 32'hffff_ffff;
    endcase
  end

  // The remainder unit takes the final hash value as it is being latched.
  bfm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (h_nxt),
    .divisor  (modulus),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    bidx_nxt      = bidx_r;
    last_nxt      = last_r;
    func_nxt      = func_r;
    klen_nxt      = klen_r;
    ovf_nxt       = ovf_r;
    probe_nxt     = probe_r;
    blk_nxt       = blk_r;
    h_nxt         = h_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a         = h_r;
    mul_b         = H_MUL;
    kwe           = 1'b0;
    kbyte         = word_r[8*bidx_r[1:0] +: 8];
    bwe           = 1'b0;
    bwaddr        = pos;
    bwdata        = 1'b1;
    mod_start     = 1'b0;
    t             = '0;
    in_stall      = 1'b1;

    case (state_r)
      ST_CLEAR: begin
        bwe    = 1'b1;
        bwaddr = clr_r;
        bwdata = 1'b0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_BITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          word_nxt  = in_data.key_word;
          cnt_nxt   = bc_sat;
          bidx_nxt  = '0;
          last_nxt  = in_data.last;
          func_nxt  = in_data.func;
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (bidx_r != cnt_r) begin
          if (klen_r < LW'(MAX_KEY_BYTES)) begin
            kwe      = 1'b1;
            klen_nxt = klen_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          bidx_nxt = bidx_r + 3'd1;
        end else if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (ovf_r) begin
          found_nxt  = 1'b0;
          status_nxt = STATUS_OVERFLOW;
          state_nxt  = ST_EMIT;
        end else if (probes == '0) begin
          found_nxt  = (func_r == FUNC_LOOKUP);
          status_nxt = STATUS_DONE;
          state_nxt  = ST_EMIT;
        end else begin
          found_nxt  = 1'b1;
          status_nxt = STATUS_DONE;
          probe_nxt  = '0;
          state_nxt  = ST_PINIT;
        end
      end
      ST_PINIT: begin
        h_nxt   = 32'(probe_r);
        blk_nxt = '0;
        if (nblocks == '0 && tail == 2'd0) begin
          state_nxt = ST_F1;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_K1;
      end
      ST_K1: begin
        mul_a     = (blk_r == nblocks) ? (krd_r & kmask) : krd_r;
        mul_b     = C1;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        mul_a     = rotl32(p_r, 5'd15);
        mul_b     = C2;
        state_nxt = ST_K3;
      end
      ST_K3: begin
        t = h_r ^ p_r;
        if (blk_r == nblocks) begin
          h_nxt     = t;
          state_nxt = ST_F1;
        end else begin
          mul_a     = rotl32(t, 5'd13);
          mul_b     = H_MUL;
          state_nxt = ST_H5;
        end
      end
      ST_H5: begin
        h_nxt   = p_r + H_ADD;
        blk_nxt = blk_r + BW'(1);
        if ((blk_r + BW'(1)) < nblocks ||
            ((blk_r + BW'(1)) == nblocks && tail != 2'd0)) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_F1;
        end
      end
      ST_F1: begin
        t         = h_r ^ 32'(klen_r);
        mul_a     = t ^ (t >> 16);
        mul_b     = C3;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        mul_a     = p_r ^ (p_r >> 13);
        mul_b     = C4;
        state_nxt = ST_F3;
      end
      ST_F3: begin
        h_nxt     = p_r ^ (p_r >> 16);
        mod_start = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        state_nxt = mod_done ? ST_BIT : ST_MOD;
      end
      ST_BIT: begin
        if (func_r == FUNC_ADD) begin
          bwe = 1'b1;
          if (last_probe) begin
            state_nxt = ST_EMIT;
          end else begin
            probe_nxt = probe_r + PW'(1);
            state_nxt = ST_PINIT;
          end
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!brd_r) begin
          found_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else if (last_probe) begin
          state_nxt = ST_EMIT;
        end else begin
          probe_nxt = probe_r + PW'(1);
          state_nxt = ST_PINIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.found  = (func_r == FUNC_LOOKUP) && found_r &&
                                (status_r == STATUS_DONE);
          out_data_nxt.status = status_r;
          klen_nxt            = '0;
          ovf_nxt             = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      klen_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      klen_r      <= klen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r     <= word_nxt;
    cnt_r      <= cnt_nxt;
    bidx_r     <= bidx_nxt;
    last_r     <= last_nxt;
    func_r     <= func_nxt;
    probe_r    <= probe_nxt;
    blk_r      <= blk_nxt;
    h_r        <= h_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    p_r        <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[klen_r[KA+1:2]][8*klen_r[1:0] +: 8] <= kbyte;
    end
    krd_r <= kmem[blk_r[KA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[bwaddr] <= bwdata;
    end
    brd_r <= bmem[pos];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_klen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    klen_r <= LW'(MAX_KEY_BYTES))
    else $error("key length beyond buffer");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit state");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result during store clear");

  a_key_reset_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> klen_r == '0 && !ovf_r)
    else $error("key state not cleared after result");
`endif

endmodule
